@@ design/apl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio peak level meter package
// Shared types, register indexes, format codes and format helpers.
// ----------------------------------------------------------------------------
package apl_pkg;

  localparam int unsigned SampleBits   = 32;
  localparam int unsigned LevelBits    = 17;
  localparam int unsigned CfgIdxBits   = 2;
  localparam int unsigned CfgDataBits  = 2;
  localparam int unsigned OutTdataBits = 56;

  localparam logic [CfgIdxBits-1:0] CfgIdxWidth  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgIdxKind   = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgIdxEndian = 2'd2;

  localparam logic [1:0] Width8  = 2'd0;
  localparam logic [1:0] Width16 = 2'd1;
  localparam logic [1:0] Width32 = 2'd2;

  localparam logic [1:0] KindUnsigned = 2'd0;
  localparam logic [1:0] KindSigned   = 2'd1;
  localparam logic [1:0] KindFloat    = 2'd2;

  localparam logic [1:0] ResetWidth  = Width16;
  localparam logic [1:0] ResetKind   = KindSigned;
  localparam logic       ResetEndian = 1'b0;

  localparam logic [LevelBits-1:0] LevelFull = 17'h10000;

  typedef struct packed {
    logic [1:0] width;
    logic [1:0] kind;
    logic       big_endian;
  } cfg_t;

  typedef struct packed {
    logic                  last;
    logic [SampleBits-1:0] mag;
  } mag_item_t;

  typedef enum logic [2:0] {
    FMT_NONE,
    FMT_U8,
    FMT_S8,
    FMT_U16,
    FMT_S16,
    FMT_U32,
    FMT_S32,
    FMT_F32
  } fmt_e;

  function automatic fmt_e get_fmt(cfg_t c);
    fmt_e f;
    case ({c.width, c.kind})
      {Width8, KindUnsigned}:  f = FMT_U8;
      {Width8, KindSigned}:    f = FMT_S8;
      {Width16, KindUnsigned}: f = FMT_U16;
      {Width16, KindSigned}:   f = FMT_S16;
      {Width32, KindUnsigned}: f = FMT_U32;
      {Width32, KindSigned}:   f = FMT_S32;
      {Width32, KindFloat}:    f = FMT_F32;
      default:                 f = FMT_NONE;
    endcase
    return f;
  endfunction

  function automatic logic [SampleBits-1:0] full_scale(fmt_e f);
    logic [SampleBits-1:0] fs;
    case (f)
      FMT_U8:           fs = 32'd255;
      FMT_S8:           fs = 32'd127;
      FMT_U16:          fs = 32'd65535;
      FMT_S16:          fs = 32'd32767;
      FMT_U32:          fs = 32'hffff_ffff;
      FMT_S32, FMT_F32: fs = 32'h7fff_ffff;
      default:          fs = 32'd0;
    endcase
    return fs;
  endfunction

endpackage

@@ design/apl_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds sample width, sample kind and byte order, written through a plain port.
// ----------------------------------------------------------------------------
module apl_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [apl_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [apl_pkg::CfgDataBits-1:0] cfg_data_i,
  output apl_pkg::cfg_t                   cfg_o
);

  apl_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width      <= apl_pkg::ResetWidth;
      cfg_q.kind       <= apl_pkg::ResetKind;
      cfg_q.big_endian <= apl_pkg::ResetEndian;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        apl_pkg::CfgIdxWidth:  cfg_q.width      <= cfg_data_i;
        apl_pkg::CfgIdxKind:   cfg_q.kind       <= cfg_data_i;
        apl_pkg::CfgIdxEndian: cfg_q.big_endian <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/apl_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample decoder
// Registers the raw sample, turns it into an unsigned magnitude and registers
// the magnitude together with its last-of-buffer mark.
// ----------------------------------------------------------------------------
module apl_decode (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  apl_pkg::cfg_t                  cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [apl_pkg::SampleBits-1:0] in_bytes_i,
  input  logic                           in_last_i,
  output logic                           mag_valid_o,
  input  logic                           mag_ready_i,
  output apl_pkg::mag_item_t             mag_item_o
);

  logic                           raw_valid_q;
  logic [apl_pkg::SampleBits-1:0] raw_q;
  logic                           raw_last_q;
  logic                           mag_valid_q;
  apl_pkg::mag_item_t             mag_item_q;
  logic                           mag_free;

  logic [7:0]                     b0, b1, b2, b3;
  logic [15:0]                    w16;
  logic [31:0]                    w32;
  logic [7:0]                     fexp;
  logic [23:0]                    fman;
  logic [54:0]                    fprod;
  logic [7:0]                     fshift;
  logic [54:0]                    fshifted;
  logic [31:0]                    fmag;
  logic [31:0]                    mag_d;
  apl_pkg::fmt_e                  fmt;

  assign fmt = apl_pkg::get_fmt(cfg_i);

  assign mag_free   = !mag_valid_q || mag_ready_i;
  assign in_ready_o = !raw_valid_q || mag_free;

  always_comb begin
    b0  = raw_q[7:0];
    b1  = raw_q[15:8];
    b2  = raw_q[23:16];
    b3  = raw_q[31:24];
    w16 = cfg_i.big_endian ? {b0, b1} : {b1, b0};
    w32 = cfg_i.big_endian ? {b0, b1, b2, b3} : {b3, b2, b1, b0};

    // The product mantissa * (2^31 - 1) is formed as a shift and a subtract.
    fexp     = w32[30:23];
    fman     = {1'b1, w32[22:0]};
    fprod    = {fman, 31'd0} - {31'd0, fman};
    fshift   = 8'd150 - fexp;
    fshifted = fprod >> fshift[5:0];
    if (fexp == 8'hff || fexp >= 8'd150) begin
      fmag = 32'hffff_ffff;
    end else if (fexp == 8'd0 || fshift >= 8'd55) begin
      fmag = 32'd0;
    end else if (|fshifted[54:32]) begin
      fmag = 32'hffff_ffff;
    end else begin
      fmag = fshifted[31:0];
    end

    case (fmt)
      apl_pkg::FMT_U8:  mag_d = {24'd0, b0};
      apl_pkg::FMT_S8:  mag_d = {24'd0, b0[7] ? (8'd0 - b0) : b0};
      apl_pkg::FMT_U16: mag_d = {16'd0, w16};
      apl_pkg::FMT_S16: mag_d = {16'd0, w16[15] ? (16'd0 - w16) : w16};
      apl_pkg::FMT_U32: mag_d = w32;
      apl_pkg::FMT_S32: mag_d = w32[31] ? (32'd0 - w32) : w32;
      apl_pkg::FMT_F32: mag_d = fmag;
      default:          mag_d = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_valid_q <= 1'b0;
      mag_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        raw_valid_q <= in_valid_i;
      end
      if (mag_free) begin
        mag_valid_q <= raw_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      raw_q      <= in_bytes_i;
      raw_last_q <= in_last_i;
    end
    if (raw_valid_q && mag_free) begin
      mag_item_q.mag  <= mag_d;
      mag_item_q.last <= raw_last_q;
    end
  end

  assign mag_valid_o = mag_valid_q;
  assign mag_item_o  = mag_item_q;

endmodule

@@ design/apl_peak.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak tracker and level
// Keeps the running peak, and on the last sample of a buffer clamps it,
// scales it to a Q1.16 level and loads the result register.
// ----------------------------------------------------------------------------
module apl_peak (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  apl_pkg::cfg_t                     cfg_i,
  input  logic                              mag_valid_i,
  output logic                              mag_ready_o,
  input  apl_pkg::mag_item_t                mag_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [apl_pkg::LevelBits-1:0]     out_level_o,
  output logic [apl_pkg::SampleBits-1:0]    out_peak_o
);

  logic [apl_pkg::SampleBits-1:0] run_peak_q;
  logic [apl_pkg::LevelBits-1:0]  held_level_q;
  logic                           out_valid_q;
  logic [apl_pkg::LevelBits-1:0]  out_level_q;
  logic [apl_pkg::SampleBits-1:0] out_peak_q;

  apl_pkg::fmt_e                  fmt;
  logic [apl_pkg::SampleBits-1:0] fs;
  logic [apl_pkg::SampleBits-1:0] new_peak;
  logic [apl_pkg::SampleBits-1:0] pk;
  logic [apl_pkg::LevelBits-1:0]  lvl;
  logic                           out_free;
  logic                           fire;

  assign fmt      = apl_pkg::get_fmt(cfg_i);
  assign fs       = apl_pkg::full_scale(fmt);
  assign new_peak = (mag_item_i.mag > run_peak_q) ? mag_item_i.mag : run_peak_q;
  assign pk       = (new_peak < fs) ? new_peak : fs;

  assign out_free    = !out_valid_q || out_ready_i;
  assign mag_ready_o = !mag_item_i.last || out_free;
  assign fire        = mag_valid_i && mag_ready_o;

  // Every full scale is 2^k - 1, so the quotient reduces to shifts and adds.
  always_comb begin
    case (fmt)
      apl_pkg::FMT_U8: begin
        lvl = {1'b0, pk[7:0], 8'd0} + {9'd0, pk[7:0]} + {16'd0, pk[7:0] == 8'hff};
      end
      apl_pkg::FMT_S8: begin
        lvl = {1'b0, pk[6:0], 9'd0} + {8'd0, pk[6:0], 2'd0} + {15'd0, pk[6:5]}
            + {16'd0, pk[6:0] == 7'h7f};
      end
      apl_pkg::FMT_U16: begin
        lvl = {1'b0, pk[15:0]} + {16'd0, pk[15:0] == 16'hffff};
      end
      apl_pkg::FMT_S16: begin
        lvl = {1'b0, pk[14:0], 1'b0} + {16'd0, pk[14]} + {16'd0, pk[14:0] == 15'h7fff};
      end
      apl_pkg::FMT_U32: begin
        lvl = (pk == fs) ? apl_pkg::LevelFull : {1'b0, pk[31:16]};
      end
      apl_pkg::FMT_S32, apl_pkg::FMT_F32: begin
        lvl = (pk == fs) ? apl_pkg::LevelFull : {1'b0, pk[30:15]};
      end
      default: begin
        lvl = held_level_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_peak_q   <= '0;
      held_level_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        if (mag_item_i.last) begin
          run_peak_q <= '0;
          if (fmt != apl_pkg::FMT_NONE) begin
            held_level_q <= lvl;
          end
        end else begin
          run_peak_q <= new_peak;
        end
      end
      if (fire && mag_item_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && mag_item_i.last) begin
      out_level_q <= lvl;
      out_peak_q  <= (fmt == apl_pkg::FMT_NONE) ? '0 : pk;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_level_o = out_level_q;
  assign out_peak_o  = out_peak_q;

  a_peak_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !mag_item_i.last |=> run_peak_q >= $past(run_peak_q))
    else $error("running peak decreased on a sample without the last mark");

  a_peak_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && mag_item_i.last |=> run_peak_q == '0 && out_valid_q)
    else $error("last sample did not clear the peak and load a result");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_level_q <= apl_pkg::LevelFull)
    else $error("level above full scale");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_peak_q))
    else $error("pending result was overwritten");

endmodule

@@ design/audio_peak_level_meter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio peak level meter
// Tracks the peak magnitude of raw audio samples and reports a Q1.16 level
// at the end of each buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the slave stream, one per transaction: tdata holds the
//   raw bytes in memory order and tlast marks the final sample of a buffer.
//   Only a sample with tlast set produces a result transaction on the master
//   stream; tdata carries the Q1.16 level and the clamped peak.
//   Width, kind and byte order are written through the configuration port
//   while no samples are in flight.
//   A sample is registered, decoded to a magnitude in the next stage and
//   folded into the peak in the stage after that, where a marked sample
//   loads the result register. One sample is accepted every cycle while
//   nothing stalls; the three register stages hold up to two samples and
//   one result while the receiver stalls. A stalled result holds a marked
//   sample at the peak stage; unmarked ones before it keep flowing.
//   Reset empties the pipeline, clears the peak and the held level, and
//   selects 16-bit signed little-endian samples.
// ----------------------------------------------------------------------------
module audio_peak_level_meter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Bits 31:0 sample_bytes.
  input  logic [apl_pkg::SampleBits-1:0]      s_axis_tdata,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Bits 16:0 level, bits 48:17 peak_value, bits 55:49 zero.
  output logic [apl_pkg::OutTdataBits-1:0]    m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [apl_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [apl_pkg::CfgDataBits-1:0]     cfg_data_i
);

  apl_pkg::cfg_t                  cfg;
  logic                           mag_valid;
  logic                           mag_ready;
  apl_pkg::mag_item_t             mag_item;
  logic [apl_pkg::LevelBits-1:0]  level;
  logic [apl_pkg::SampleBits-1:0] peak_value;

  apl_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  apl_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_bytes_i  (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .mag_valid_o (mag_valid),
    .mag_ready_i (mag_ready),
    .mag_item_o  (mag_item)
  );

  apl_peak u_peak (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .mag_valid_i (mag_valid),
    .mag_ready_o (mag_ready),
    .mag_item_i  (mag_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_level_o (level),
    .out_peak_o  (peak_value)
  );

  assign m_axis_tdata = {7'd0, peak_value, level};

endmodule
